FILE: hdl/cfmd_pkg.sv
// Shared types, codes and the CRC-8 nibble step of the framed message deframer.
// Standalone package; cfmd_crc and the top level refer to it by scoped name.
`timescale 1ns / 1ps

package cfmd_pkg;

  // Reflected Dallas/Maxim CRC-8 polynomial and the start byte after reset.
  localparam logic [7:0] CRC_POLY    = 8'h8C;
  localparam logic [7:0] START_RESET = 8'h3A;
  localparam int         NIB_BITS    = 4;

  // Frame phase as the received stream is parsed.
  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_CODE = 3'd1,
    PH_LEN  = 3'd2,
    PH_DATA = 3'd3,
    PH_CRC  = 3'd4
  } phase_t;

  // Result kinds on the result channel.
  typedef enum logic [1:0] {
    KIND_HDR      = 2'd0,
    KIND_PAY      = 2'd1,
    KIND_BAD_CRC  = 2'd2,
    KIND_TOO_LONG = 2'd3
  } kind_t;

  // Sequencer states of the top level.
  typedef enum logic [2:0] {
    SQ_IDLE = 3'd0,
    SQ_FIN  = 3'd1,
    SQ_ONE  = 3'd2,
    SQ_RD   = 3'd3,
    SQ_PAY  = 3'd4
  } seq_t;

  // Control toward the shared CRC unit.
  typedef struct packed {
    logic start;      // load first nibble of a new byte
    logic seed_zero;  // start from zero instead of the running CRC
  } crc_ctl_t;

  // Four bit steps of the reflected CRC-8 shift register.
  function automatic logic [7:0] crc_nibble(input logic [7:0] c_in);
    logic [7:0] c;
    c = c_in;
    for (int b = 0; b < NIB_BITS; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: hdl/cfmd_ifs.sv
// Channel interfaces of the deframer: received bytes, results and configuration.
// Depends on nothing; plain valid/ready handshakes with source and sink modports.
`timescale 1ns / 1ps

interface cfmd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfmd_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] msg_code;
  logic [7:0] msg_length;
  logic [7:0] payload_byte;
  logic       last;

  modport source (output valid, output kind, output msg_code, output msg_length,
                  output payload_byte, output last, input ready);
  modport sink   (input valid, input kind, input msg_code, input msg_length,
                  input payload_byte, input last, output ready);
endinterface

interface cfmd_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] start_value;

  modport source (output valid, output start_value, input ready);
  modport sink   (input valid, input start_value, output ready);
endinterface

FILE: hdl/cfmd_crc.sv
// Shared CRC-8 unit: a byte in two nibble passes, the low one registered, the high one combinational.
// Depends on cfmd_pkg for the control struct and the nibble step.
`timescale 1ns / 1ps

module cfmd_crc (
  input  logic                clk,
  input  cfmd_pkg::crc_ctl_t  ctl,
  input  logic [7:0]          seed,
  input  logic [7:0]          data,
  output logic [7:0]          crc
);

  logic [7:0] acc;

  // Fold the byte in and run the low nibble on start.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      acc <= cfmd_pkg::crc_nibble((ctl.seed_zero ? 8'h00 : seed) ^ data);
    end
  end

  // High nibble completes the byte in the following cycle.
  assign crc = cfmd_pkg::crc_nibble(acc);

endmodule

FILE: hdl/cfmd_buf.sv
// Payload buffer: one write port, one registered read port.
// No package dependencies.
`timescale 1ns / 1ps

module cfmd_buf #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/crc8_framed_message_deframer_top.sv
// Top level of the CRC-8 framed message deframer.
// Depends on cfmd_pkg, the interfaces in cfmd_ifs, cfmd_crc and cfmd_buf.
// Flow: one received byte is in flight at a time; it is accepted in SQ_IDLE and
//   finished in SQ_FIN. A frame end adds SQ_ONE for each single result and SQ_RD
//   then SQ_PAY per payload byte (buffer read, then output load); both wait while stalled.
// First result of a frame: its CRC byte is finished in SQ_FIN, then loaded out from SQ_ONE.
// Reset (rst, synchronous): hunting, CRC and held fields zero, start byte 0x3A.
`timescale 1ns / 1ps

module crc8_framed_message_deframer_top #(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic        clk,
  input  logic        rst,
  cfmd_byte_if.sink   rx,
  cfmd_res_if.source  res,
  cfmd_cfg_if.sink    cfg
);

  localparam int         AW      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

  // Sequencer and frame state.
  cfmd_pkg::seq_t   seq, seq_next;
  cfmd_pkg::phase_t phase;
  cfmd_pkg::kind_t  pend_kind;
  logic [7:0]       running_crc;
  logic [7:0]       held_code;
  logic [7:0]       held_length;
  logic [5:0]       byte_count;
  logic [5:0]       rd_idx;
  logic [7:0]       byte_q;
  logic [7:0]       start_value;

  // Output register.
  logic             out_valid;
  cfmd_pkg::kind_t  out_kind;
  logic [7:0]       out_code;
  logic [7:0]       out_len;
  logic [7:0]       out_pay;
  logic             out_last;

  // Datapath wiring.
  logic                accept_in;
  logic                can_load;
  logic                load_out;
  logic                hunting;
  logic                pay_last;
  logic [7:0]          new_crc;
  logic [5:0]          count_inc;
  logic [7:0]          mem_rdata;
  logic                mem_we;
  logic                mem_re;
  cfmd_pkg::crc_ctl_t  crc_ctl;

  // Take one byte at a time; the configuration port never stalls.
  assign rx.ready  = (seq == cfmd_pkg::SQ_IDLE);
  assign cfg.ready = 1'b1;
  assign accept_in = rx.valid && rx.ready;

  // The output register can load when empty or when its request leaves now.
  assign can_load = !out_valid || res.ready;
  assign load_out = can_load && (seq == cfmd_pkg::SQ_ONE || seq == cfmd_pkg::SQ_PAY);

  assign res.valid        = out_valid;
  assign res.kind         = out_kind;
  assign res.msg_code     = out_code;
  assign res.msg_length   = out_len;
  assign res.payload_byte = out_pay;
  assign res.last         = out_last;

  // Unknown phase codes behave as hunting.
  assign hunting = !(phase == cfmd_pkg::PH_CODE || phase == cfmd_pkg::PH_LEN ||
                     phase == cfmd_pkg::PH_DATA || phase == cfmd_pkg::PH_CRC);

  assign crc_ctl.start     = accept_in;
  assign crc_ctl.seed_zero = hunting;

  assign count_inc = 6'(byte_count + 6'd1);
  assign pay_last  = (({2'b00, rd_idx} + 8'd1) == held_length);

  // Store payload while the byte is finished; read ahead of each payload result.
  assign mem_we = (seq == cfmd_pkg::SQ_FIN) && (phase == cfmd_pkg::PH_DATA);
  assign mem_re = (seq == cfmd_pkg::SQ_RD);

  cfmd_crc u_crc (
    .clk  (clk),
    .ctl  (crc_ctl),
    .seed (running_crc),
    .data (rx.rx_byte),
    .crc  (new_crc)
  );

  cfmd_buf #(
    .DEPTH (MAX_PAYLOAD),
    .AW    (AW)
  ) u_buf (
    .clk   (clk),
    .we    (mem_we),
    .waddr (byte_count[AW-1:0]),
    .wdata (byte_q),
    .re    (mem_re),
    .raddr (rd_idx[AW-1:0]),
    .rdata (mem_rdata)
  );

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= cfmd_pkg::SQ_IDLE;
    end else begin
      seq <= seq_next;
    end
  end

  // Next state: accept, finish the byte, then emit any results it causes.
  always_comb begin
    seq_next = seq;
    unique case (seq)
      cfmd_pkg::SQ_IDLE: begin
        if (accept_in) seq_next = cfmd_pkg::SQ_FIN;
      end
      cfmd_pkg::SQ_FIN: begin
        seq_next = cfmd_pkg::SQ_IDLE;
        if (phase == cfmd_pkg::PH_CRC) begin
          seq_next = cfmd_pkg::SQ_ONE;
        end else if (phase == cfmd_pkg::PH_LEN && byte_q > MAX_LEN) begin
          seq_next = cfmd_pkg::SQ_ONE;
        end
      end
      cfmd_pkg::SQ_ONE: begin
        if (can_load) begin
          seq_next = (pend_kind == cfmd_pkg::KIND_HDR && held_length != 8'd0) ?
                     cfmd_pkg::SQ_RD : cfmd_pkg::SQ_IDLE;
        end
      end
      cfmd_pkg::SQ_RD: begin
        seq_next = cfmd_pkg::SQ_PAY;
      end
      cfmd_pkg::SQ_PAY: begin
        if (can_load) seq_next = pay_last ? cfmd_pkg::SQ_IDLE : cfmd_pkg::SQ_RD;
      end
      default: begin
        seq_next = cfmd_pkg::SQ_IDLE;
      end
    endcase
  end

  // Frame state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= cfmd_pkg::PH_HUNT;
      running_crc <= 8'h00;
      held_code   <= 8'h00;
      held_length <= 8'h00;
      byte_count  <= 6'd0;
      rd_idx      <= 6'd0;
      start_value <= cfmd_pkg::START_RESET;
      out_valid   <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) start_value <= cfg.start_value;
      if (accept_in) byte_q <= rx.rx_byte;
      // Load a new request, or drop the held one once the sink takes it.
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && res.ready) begin
        out_valid <= 1'b0;
      end

      unique case (seq)
        cfmd_pkg::SQ_FIN: begin
          // Commit the finished CRC and advance the frame phase.
          unique case (phase)
            cfmd_pkg::PH_CODE: begin
              running_crc <= new_crc;
              held_code   <= byte_q;
              phase       <= cfmd_pkg::PH_LEN;
            end
            cfmd_pkg::PH_LEN: begin
              running_crc <= new_crc;
              held_length <= byte_q;
              byte_count  <= 6'd0;
              if (byte_q > MAX_LEN) begin
                // Length beyond the buffer: flag and drop the frame.
                pend_kind <= cfmd_pkg::KIND_TOO_LONG;
                phase     <= cfmd_pkg::PH_HUNT;
              end else if (byte_q == 8'd0) begin
                phase <= cfmd_pkg::PH_CRC;
              end else begin
                phase <= cfmd_pkg::PH_DATA;
              end
            end
            cfmd_pkg::PH_DATA: begin
              running_crc <= new_crc;
              byte_count  <= count_inc;
              if ({2'b00, count_inc} >= held_length) phase <= cfmd_pkg::PH_CRC;
            end
            cfmd_pkg::PH_CRC: begin
              // CRC over the whole frame including its CRC byte must be zero.
              running_crc <= new_crc;
              pend_kind   <= (new_crc == 8'h00) ? cfmd_pkg::KIND_HDR :
                                                  cfmd_pkg::KIND_BAD_CRC;
              rd_idx      <= 6'd0;
              phase       <= cfmd_pkg::PH_HUNT;
            end
            default: begin
              // Hunting: open a frame only on the start byte.
              if (byte_q == start_value) begin
                running_crc <= new_crc;
                held_code   <= 8'h00;
                held_length <= 8'h00;
                byte_count  <= 6'd0;
                phase       <= cfmd_pkg::PH_CODE;
              end else begin
                phase <= cfmd_pkg::PH_HUNT;
              end
            end
          endcase
        end
        cfmd_pkg::SQ_ONE: begin
          // Header, bad CRC or length error.
          if (can_load) begin
            out_kind  <= pend_kind;
            out_code  <= held_code;
            out_len   <= held_length;
            out_pay   <= 8'h00;
            out_last  <= !(pend_kind == cfmd_pkg::KIND_HDR && held_length != 8'd0);
          end
        end
        cfmd_pkg::SQ_PAY: begin
          if (can_load) begin
            out_kind  <= cfmd_pkg::KIND_PAY;
            out_code  <= held_code;
            out_len   <= held_length;
            out_pay   <= mem_rdata;
            out_last  <= pay_last;
            rd_idx    <= 6'(rd_idx + 6'd1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // One byte in flight: no request is taken right after one was taken.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (rx.valid && rx.ready) |=> !rx.ready)
    else $error("input taken while a byte is in flight");

  // Payload fill count stays below the frame length.
  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    (phase == cfmd_pkg::PH_DATA) |-> ({2'b00, byte_count} < held_length))
    else $error("payload count reached frame length in data phase");

  // The running CRC changes only when a byte is finished.
  a_crc_commit: assert property (@(posedge clk) disable iff (rst)
    (seq != cfmd_pkg::SQ_FIN) |=> $stable(running_crc))
    else $error("running CRC changed outside byte completion");

  // Payload is streamed only after a good header.
  a_pay_after_hdr: assert property (@(posedge clk) disable iff (rst)
    (seq == cfmd_pkg::SQ_PAY || seq == cfmd_pkg::SQ_RD) |->
      (pend_kind == cfmd_pkg::KIND_HDR))
    else $error("payload streamed for a frame without a good CRC");

endmodule
